// File: hw/rtl/masked_word_pattern_scanner_macros.svh
// ----------------------------------------------------------------------------
// Masked word pattern scanner assertion macros
// Shared concurrent assertion forms for the scanner design.
// ----------------------------------------------------------------------------
`ifndef MASKED_WORD_PATTERN_SCANNER_MACROS_SVH
`define MASKED_WORD_PATTERN_SCANNER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MWPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MWPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mwps_pkg.sv
// ----------------------------------------------------------------------------
// Masked word pattern scanner package
// Fixed constants, register indexes and the masked compare function.
// ----------------------------------------------------------------------------
package mwps_pkg;

   localparam int WORD_BITS      = 32;
   localparam int WINDOW_WORDS   = 3;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [WORD_BITS-1:0]      word_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_PATTERN_FIRST   = 3'd0;
   localparam csr_index_type CSR_PATTERN_SECOND  = 3'd1;
   localparam csr_index_type CSR_PATTERN_THIRD   = 3'd2;
   localparam csr_index_type CSR_CARE_FIRST      = 3'd3;
   localparam csr_index_type CSR_CARE_SECOND     = 3'd4;
   localparam csr_index_type CSR_CARE_THIRD      = 3'd5;
   localparam csr_index_type CSR_SCAN_START_WORD = 3'd6;
   localparam csr_index_type CSR_SCAN_END_WORD   = 3'd7;

   localparam word_type PATTERN_RESET    = 32'h0000_0000;
   localparam word_type CARE_RESET       = 32'hFFFF_FFFF;
   localparam word_type START_WORD_RESET = 32'h0002_0000;
   localparam word_type END_WORD_RESET   = 32'h00A0_0000;

   // True when every bit selected by care agrees between word and pattern.
   function automatic logic masked_match(input word_type word,
                                         input word_type pattern,
                                         input word_type care);
      return ((word ^ pattern) & care) == '0;
   endfunction

endpackage

// File: hw/rtl/mwps_req_if.sv
// ----------------------------------------------------------------------------
// Scanner request channel
// Carries one image word and its final-word marker per handshake.
// ----------------------------------------------------------------------------
interface mwps_req_if;
   logic                 valid;
   logic                 ready;
   mwps_pkg::word_type   image_word;
   logic                 final_word;

   modport source (output valid, output image_word, output final_word, input ready);
   modport sink   (input valid, input image_word, input final_word, output ready);
endinterface

// File: hw/rtl/mwps_rsp_if.sv
// ----------------------------------------------------------------------------
// Scanner response channel
// Carries the found flag and byte offset of one scanned image.
// ----------------------------------------------------------------------------
interface mwps_rsp_if #(
   parameter int INDEX_BITS = 24
);
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [INDEX_BITS+1:0]   byte_offset;

   modport source (output valid, output found, output byte_offset, input ready);
   modport sink   (input valid, input found, input byte_offset, output ready);
endinterface

// File: hw/rtl/mwps_cell.sv
// ----------------------------------------------------------------------------
// Scanner window cell
// Holds one window word, shifts it on to the next cell and compares it.
// ----------------------------------------------------------------------------
module mwps_cell (
   input  logic               clock,
   input  logic               load,
   input  mwps_pkg::word_type word_in,
   input  mwps_pkg::word_type pattern,
   input  mwps_pkg::word_type care,
   output mwps_pkg::word_type word_out,
   output logic               hit
);

   mwps_pkg::word_type word_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;
   assign hit      = mwps_pkg::masked_match(word_ff, pattern, care);

endmodule

// File: hw/rtl/masked_word_pattern_scanner.sv
// ----------------------------------------------------------------------------
// Masked word pattern scanner
// Finds the first three-word masked pattern inside a range of an image stream.
// ----------------------------------------------------------------------------
// The scanner takes one 32-bit image word per cycle on the request channel and
// reports, on the word marked final, whether a window of three consecutive
// words matched the pattern registers under the care masks, together with the
// byte offset (four times the start word index) of the first such window, or
// zero when none matched. The window is a short chain of cells that shifts
// one word per accepted word, and the compare of the stored words with the
// newest one is combinational. Results sit in an output register, so words
// keep flowing while a result is being taken; only a result that is still
// waiting stalls the next word. A start index counts only if it is at least
// scan_start_word and, plus three, below scan_end_word. After the final word
// the word counter and match state start over; the window cells are not
// cleared and the registers keep their values. Registers should be written
// only between images.
// ----------------------------------------------------------------------------
module masked_word_pattern_scanner #(
   parameter int INDEX_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  mwps_pkg::csr_index_type       csr_index,
   input  mwps_pkg::word_type            csr_wdata,
   mwps_req_if.sink                      req_chan,
   mwps_rsp_if.source                    rsp_chan
);

`include "masked_word_pattern_scanner_macros.svh"

   localparam int CountBits  = INDEX_BITS + 1;
   localparam int OffsetBits = INDEX_BITS + 2;
   localparam int Cells      = mwps_pkg::WINDOW_WORDS - 1;

   // Configuration registers. Index 0 of the arrays is the oldest window word.
   mwps_pkg::word_type       pattern_ff [mwps_pkg::WINDOW_WORDS];
   mwps_pkg::word_type       care_ff    [mwps_pkg::WINDOW_WORDS];
   logic [INDEX_BITS-1:0]    start_ff;
   logic [CountBits-1:0]     end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < mwps_pkg::WINDOW_WORDS; k++) begin
            pattern_ff[k] <= mwps_pkg::PATTERN_RESET;
            care_ff[k]    <= mwps_pkg::CARE_RESET;
         end
         start_ff <= mwps_pkg::START_WORD_RESET[INDEX_BITS-1:0];
         end_ff   <= mwps_pkg::END_WORD_RESET[CountBits-1:0];
      end else if (csr_write_en) begin
         unique case (csr_index)
            mwps_pkg::CSR_PATTERN_FIRST:   pattern_ff[0] <= csr_wdata;
            mwps_pkg::CSR_PATTERN_SECOND:  pattern_ff[1] <= csr_wdata;
            mwps_pkg::CSR_PATTERN_THIRD:   pattern_ff[2] <= csr_wdata;
            mwps_pkg::CSR_CARE_FIRST:      care_ff[0]    <= csr_wdata;
            mwps_pkg::CSR_CARE_SECOND:     care_ff[1]    <= csr_wdata;
            mwps_pkg::CSR_CARE_THIRD:      care_ff[2]    <= csr_wdata;
            mwps_pkg::CSR_SCAN_START_WORD: start_ff      <= csr_wdata[INDEX_BITS-1:0];
            mwps_pkg::CSR_SCAN_END_WORD:   end_ff        <= csr_wdata[CountBits-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake. A word is taken unless a result is still waiting at the output.
   logic rsp_valid_ff;
   logic accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Window chain. The newest cell is fed by the request word, and each cell
   // passes its word to the next older cell when a word is accepted.
   mwps_pkg::word_type cell_word [Cells];
   logic [Cells-1:0]   cell_hit;

   for (genvar k = 0; k < Cells; k++) begin : g_cell
      mwps_pkg::word_type feed;
      if (k == Cells - 1) begin : g_newest
         assign feed = req_chan.image_word;
      end else begin : g_inner
         assign feed = cell_word[k+1];
      end

      mwps_cell u_cell (
         .clock    (clock),
         .load     (accept),
         .word_in  (feed),
         .pattern  (pattern_ff[k]),
         .care     (care_ff[k]),
         .word_out (cell_word[k]),
         .hit      (cell_hit[k])
      );
   end

   logic newest_hit;
   logic window_hit;

   assign newest_hit = mwps_pkg::masked_match(req_chan.image_word,
                                              pattern_ff[mwps_pkg::WINDOW_WORDS-1],
                                              care_ff[mwps_pkg::WINDOW_WORDS-1]);
   assign window_hit = (&cell_hit) && newest_hit;

   // Word counter and range check for the window start.
   logic [CountBits-1:0]   word_count_ff;
   logic [CountBits-1:0]   word_count_in;
   logic                   match_seen_ff;
   logic                   match_seen_in;
   logic [INDEX_BITS-1:0]  match_index_ff;
   logic [INDEX_BITS-1:0]  match_index_in;

   logic [OffsetBits-1:0]  count_ext;
   logic [OffsetBits-1:0]  start_pos;
   logic                   window_full;
   logic                   in_range;
   logic                   take_match;

   assign count_ext   = {1'b0, word_count_ff};
   assign window_full = count_ext >= OffsetBits'(Cells);
   assign start_pos   = count_ext - OffsetBits'(Cells);
   assign in_range    = window_full
                        && (start_pos >= {2'b00, start_ff})
                        && ((start_pos + OffsetBits'(mwps_pkg::WINDOW_WORDS))
                            < {1'b0, end_ff});
   assign take_match  = !match_seen_ff && in_range && window_hit;

   always_comb begin
      word_count_in  = word_count_ff;
      match_seen_in  = match_seen_ff;
      match_index_in = match_index_ff;
      if (take_match) begin
         match_seen_in  = 1'b1;
         match_index_in = start_pos[INDEX_BITS-1:0];
      end
      // The counter holds once it reaches its largest value.
      if (word_count_ff != '1) begin
         word_count_in = word_count_ff + CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff  <= '0;
         match_seen_ff  <= 1'b0;
         match_index_ff <= '0;
      end else if (accept) begin
         if (req_chan.final_word) begin
            word_count_ff  <= '0;
            match_seen_ff  <= 1'b0;
            match_index_ff <= '0;
         end else begin
            word_count_ff  <= word_count_in;
            match_seen_ff  <= match_seen_in;
            match_index_ff <= match_index_in;
         end
      end
   end

   // Output register, loaded by the final word of each image.
   logic                   rsp_found_ff;
   logic [OffsetBits-1:0]  rsp_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_chan.final_word) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.final_word) begin
         rsp_found_ff  <= match_seen_in;
         rsp_offset_ff <= match_seen_in ? {match_index_in, 2'b00} : '0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.byte_offset = rsp_offset_ff;

   // A waiting result must block the next word so it cannot be overwritten.
   `MWPS_ASSERT_SAME(a_hold_input, clock, reset, rsp_valid_ff && !rsp_chan.ready, !req_chan.ready, "input accepted while a result waits")
   // A final word leaves a result and a cleared scan behind.
   `MWPS_ASSERT_NEXT(a_final_clears, clock, reset, !reset && accept && req_chan.final_word, rsp_valid_ff && word_count_ff == '0 && !match_seen_ff, "final word did not produce a result or clear the scan")
   // The first latched match stays put until the image ends.
   `MWPS_ASSERT_NEXT(a_match_sticky, clock, reset, !reset && match_seen_ff && !(accept && req_chan.final_word), match_seen_ff && $stable(match_index_ff), "latched match changed inside an image")
   // An empty result always carries a zero offset.
   `MWPS_ASSERT_SAME(a_zero_offset, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_offset_ff == '0, "offset nonzero without a match")

endmodule

// File: verif/masked_word_pattern_scanner_tb.sv
// ----------------------------------------------------------------------------
// Masked word pattern scanner testbench
// Streams images through the scanner with random flow control. Each found
// flag and byte offset is checked against a behavioral scan of the same words
// under the same pattern, care mask and range registers.
// ----------------------------------------------------------------------------
module masked_word_pattern_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int INDEX_BITS      = 24;
   localparam int COUNT_BITS      = INDEX_BITS + 1;
   localparam int OFFSET_BITS     = INDEX_BITS + 2;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT     = 2000;
   localparam int IDLE_PERCENT    = 23;

   // Largest start value, and an end value one above it.
   localparam mwps_pkg::word_type START_WORD_MAX = 32'h00FF_FFFF;
   localparam mwps_pkg::word_type END_WORD_MAX   = 32'h0100_0000;

   typedef struct packed {
      logic                   found;
      logic [OFFSET_BITS-1:0] byte_offset;
   } scan_result_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write_en;
   mwps_pkg::csr_index_type csr_index;
   mwps_pkg::word_type      csr_wdata;

   mwps_req_if                          req_if ();
   mwps_rsp_if #(.INDEX_BITS(INDEX_BITS)) rsp_if ();

   masked_word_pattern_scanner #(
      .INDEX_BITS (INDEX_BITS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copies of the scanner registers, kept in step with every write.
   mwps_pkg::word_type    pattern_reg [3];
   mwps_pkg::word_type    care_reg [3];
   logic [INDEX_BITS-1:0] start_word_reg;
   logic [COUNT_BITS-1:0] end_word_reg;

   // Scan state of the image in flight: the two previous words (oldest
   // first), the index of the next word and the first latched match.
   mwps_pkg::word_type    held_words [2];
   logic [COUNT_BITS-1:0] word_count;
   logic                  match_seen;
   logic [INDEX_BITS-1:0] match_index;

   scan_result_type expected_results [$];

   int unsigned fail_count = 0;
   // When set, neither side inserts idle cycles.
   bit          steady_flow = 1'b0;
   // A nonzero value asks the result receiver to hold off for that many cycles.
   int unsigned rsp_hold_request = 0;

   function automatic void clear_scan();
      held_words[0] = '0;
      held_words[1] = '0;
      word_count    = '0;
      match_seen    = 1'b0;
      match_index   = '0;
   endfunction

   function automatic void reset_scan_model();
      pattern_reg    = '{mwps_pkg::PATTERN_RESET, mwps_pkg::PATTERN_RESET,
                         mwps_pkg::PATTERN_RESET};
      care_reg       = '{mwps_pkg::CARE_RESET, mwps_pkg::CARE_RESET,
                         mwps_pkg::CARE_RESET};
      start_word_reg = mwps_pkg::START_WORD_RESET[INDEX_BITS-1:0];
      end_word_reg   = mwps_pkg::END_WORD_RESET[COUNT_BITS-1:0];
      clear_scan();
   endfunction

   // Advances the scan by one accepted word. The window that ends on this word
   // starts two words back; it is a candidate only if that start lies inside
   // the configured range. On the final word the result of the image is queued
   // and the scan starts over.
   function automatic void predict_word(mwps_pkg::word_type word, logic last);
      logic [COUNT_BITS:0] first_idx;
      logic                hit;
      scan_result_type     result;
      if (!match_seen && word_count >= mwps_pkg::WINDOW_WORDS - 1) begin
         first_idx = (COUNT_BITS + 1)'(word_count - (mwps_pkg::WINDOW_WORDS - 1));
         hit = (((held_words[0] ^ pattern_reg[0]) & care_reg[0]) == '0) &&
               (((held_words[1] ^ pattern_reg[1]) & care_reg[1]) == '0) &&
               (((word ^ pattern_reg[2]) & care_reg[2]) == '0);
         if (hit && first_idx >= start_word_reg &&
             first_idx + mwps_pkg::WINDOW_WORDS < end_word_reg) begin
            match_seen  = 1'b1;
            match_index = first_idx[INDEX_BITS-1:0];
         end
      end
      held_words[0] = held_words[1];
      held_words[1] = word;
      // The counter saturates instead of wrapping.
      if (word_count != '1)
         word_count = word_count + 1'b1;
      if (last) begin
         result.found       = match_seen;
         result.byte_offset = match_seen ? {match_index, 2'b00} : '0;
         expected_results.push_back(result);
         clear_scan();
      end
   endfunction

   // Register writes are only issued while the scanner is idle.
   task automatic write_reg(mwps_pkg::csr_index_type idx, mwps_pkg::word_type value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         mwps_pkg::CSR_PATTERN_FIRST:   pattern_reg[0] = value;
         mwps_pkg::CSR_PATTERN_SECOND:  pattern_reg[1] = value;
         mwps_pkg::CSR_PATTERN_THIRD:   pattern_reg[2] = value;
         mwps_pkg::CSR_CARE_FIRST:      care_reg[0] = value;
         mwps_pkg::CSR_CARE_SECOND:     care_reg[1] = value;
         mwps_pkg::CSR_CARE_THIRD:      care_reg[2] = value;
         mwps_pkg::CSR_SCAN_START_WORD: start_word_reg = value[INDEX_BITS-1:0];
         mwps_pkg::CSR_SCAN_END_WORD:   end_word_reg = value[COUNT_BITS-1:0];
         default: ;
      endcase
   endtask

   // Offers one word and returns at the edge where it is accepted, with valid
   // still high. The next call either keeps valid up for a back-to-back word
   // or lowers it for an idle cycle, so valid gets one update per edge.
   task automatic send_word(mwps_pkg::word_type word, logic last);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.image_word <= word;
      req_if.final_word <= last;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      predict_word(word, last);
   endtask

   // Sends the three pattern words exactly as configured.
   task automatic send_triple(logic last);
      send_word(pattern_reg[0], 1'b0);
      send_word(pattern_reg[1], 1'b0);
      send_word(pattern_reg[2], last);
   endtask

   // Sends one whole image of random words with a number of matching windows
   // planted at random places. Planted words only honor the cared-for bits, so
   // the don't-care bits stay random.
   task automatic send_random_image(int unsigned length, int unsigned plants);
      mwps_pkg::word_type words [$];
      int unsigned        at;
      repeat (length) words.push_back($urandom());
      if (length >= mwps_pkg::WINDOW_WORDS) begin
         repeat (plants) begin
            at = $urandom_range(length - mwps_pkg::WINDOW_WORDS);
            for (int k = 0; k < mwps_pkg::WINDOW_WORDS; k++)
               words[at + k] = (pattern_reg[k] & care_reg[k]) |
                               ($urandom() & ~care_reg[k]);
         end
      end
      foreach (words[i])
         send_word(words[i], i == words.size() - 1);
   endtask

   // Drops valid at the edge of the last accepted word, waits for every
   // queued result and then lets the scanner settle before any register write.
   task automatic wait_scanner_idle();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic mwps_pkg::word_type random_care();
      case ($urandom_range(4))
         0:       return '1;
         1:       return '0;
         2:       return $urandom();
         default: return $urandom() & $urandom() & $urandom();
      endcase
   endfunction

   // Small ranges keep matches within reach of short images; the extremes
   // show up every few phases.
   task automatic load_random_setup();
      mwps_pkg::word_type start_value;
      mwps_pkg::word_type end_value;
      case ($urandom_range(7))
         0:       start_value = '0;
         1:       start_value = START_WORD_MAX;
         default: start_value = $urandom_range(12);
      endcase
      case ($urandom_range(7))
         0:       end_value = END_WORD_MAX;
         1:       end_value = $urandom_range(mwps_pkg::WINDOW_WORDS);
         default: end_value = $urandom_range(48, 4);
      endcase
      write_reg(mwps_pkg::CSR_PATTERN_FIRST, $urandom());
      write_reg(mwps_pkg::CSR_PATTERN_SECOND, $urandom());
      write_reg(mwps_pkg::CSR_PATTERN_THIRD, $urandom());
      write_reg(mwps_pkg::CSR_CARE_FIRST, random_care());
      write_reg(mwps_pkg::CSR_CARE_SECOND, random_care());
      write_reg(mwps_pkg::CSR_CARE_THIRD, random_care());
      write_reg(mwps_pkg::CSR_SCAN_START_WORD, start_value);
      write_reg(mwps_pkg::CSR_SCAN_END_WORD, end_value);
   endtask

   // With the reset registers the range begins far beyond any short image, so
   // even words that equal the pattern must not be found.
   task automatic test_reset_defaults();
      repeat (4) send_word('0, 1'b0);
      send_word('0, 1'b1);
      send_word('1, 1'b1);
      wait_scanner_idle();
   endtask

   task automatic test_directed_windows();
      write_reg(mwps_pkg::CSR_PATTERN_FIRST, '1);
      write_reg(mwps_pkg::CSR_PATTERN_SECOND, '0);
      write_reg(mwps_pkg::CSR_PATTERN_THIRD, 32'h8000_0001);
      write_reg(mwps_pkg::CSR_CARE_FIRST, '1);
      write_reg(mwps_pkg::CSR_CARE_SECOND, '1);
      write_reg(mwps_pkg::CSR_CARE_THIRD, '1);
      write_reg(mwps_pkg::CSR_SCAN_START_WORD, '0);
      write_reg(mwps_pkg::CSR_SCAN_END_WORD, END_WORD_MAX);
      // A match at word 0 must report found with a zero offset.
      send_triple(1'b1);
      // Images too short for a full window can never match.
      send_word(pattern_reg[0], 1'b0);
      send_word(pattern_reg[1], 1'b1);
      send_word(pattern_reg[0], 1'b1);
      // Two matching windows: only the first one is latched.
      send_word(~pattern_reg[0], 1'b0);
      send_triple(1'b0);
      send_triple(1'b1);
      wait_scanner_idle();
      // An end bound of three leaves no start; four admits start zero.
      write_reg(mwps_pkg::CSR_SCAN_END_WORD, mwps_pkg::WINDOW_WORDS);
      send_triple(1'b1);
      wait_scanner_idle();
      write_reg(mwps_pkg::CSR_SCAN_END_WORD, mwps_pkg::WINDOW_WORDS + 1);
      send_triple(1'b1);
      wait_scanner_idle();
      // Start above the usable end: the window at word 1 is rejected.
      write_reg(mwps_pkg::CSR_SCAN_START_WORD, 1);
      write_reg(mwps_pkg::CSR_SCAN_END_WORD, 1);
      send_word(~pattern_reg[0], 1'b0);
      send_triple(1'b1);
      wait_scanner_idle();
      // Largest start with an end bound one above it.
      write_reg(mwps_pkg::CSR_SCAN_START_WORD, START_WORD_MAX);
      write_reg(mwps_pkg::CSR_SCAN_END_WORD, END_WORD_MAX);
      send_triple(1'b1);
      wait_scanner_idle();
   endtask

   // Several register settings, each with a run of images. Most images carry
   // planted windows; the rest are plain noise.
   task automatic test_random_images();
      int unsigned phase_words;
      int unsigned length;
      repeat (6) begin
         load_random_setup();
         phase_words = 0;
         while (phase_words < 100) begin
            length = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4);
            send_random_image(length, ($urandom_range(99) < 75) ? $urandom_range(2, 1) : 0);
            phase_words += length;
         end
         wait_scanner_idle();
      end
   endtask

   // The receiver holds off for a long stretch while tiny images keep coming,
   // so results back up and the scanner has to stall its input.
   task automatic test_result_backpressure();
      write_reg(mwps_pkg::CSR_SCAN_START_WORD, '0);
      write_reg(mwps_pkg::CSR_SCAN_END_WORD, END_WORD_MAX);
      write_reg(mwps_pkg::CSR_CARE_SECOND, '0);
      steady_flow      = 1'b1;
      rsp_hold_request = RSP_HOLD_CYCLES;
      repeat (40) send_random_image($urandom_range(4, 1), 1);
      wait_scanner_idle();
      steady_flow = 1'b0;
   endtask

   // No idle cycles on either side. One long image reaches start indexes in
   // the hundreds, which drives the upper offset bits.
   task automatic test_steady_stream();
      steady_flow = 1'b1;
      write_reg(mwps_pkg::CSR_CARE_FIRST, random_care());
      write_reg(mwps_pkg::CSR_CARE_SECOND, random_care());
      write_reg(mwps_pkg::CSR_CARE_THIRD, random_care());
      write_reg(mwps_pkg::CSR_SCAN_START_WORD, 200);
      write_reg(mwps_pkg::CSR_SCAN_END_WORD, END_WORD_MAX);
      send_random_image(260, 3);
      repeat (12) send_random_image($urandom_range(40, 1), $urandom_range(2));
      wait_scanner_idle();
      steady_flow = 1'b0;
   endtask

   // Result receiver. A hold-off request is counted out here before the usual
   // random ready pattern resumes.
   initial begin : result_receiver
      int unsigned hold_left;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
            rsp_if.ready <= 1'b0;
            while (hold_left != 0) begin
               @(posedge clock);
               hold_left--;
            end
         end
         rsp_if.ready <= !reset && (steady_flow || $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Every accepted result is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      scan_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected: found %0b byte_offset %0d",
                     $time, rsp_if.found, rsp_if.byte_offset);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.found !== want.found) begin
               $display("%0t: found mismatch: expected %0b, actual %0b",
                        $time, want.found, rsp_if.found);
               fail_count++;
            end
            if (rsp_if.byte_offset !== want.byte_offset) begin
               $display("%0t: byte_offset mismatch: expected %0d, actual %0d",
                        $time, want.byte_offset, rsp_if.byte_offset);
               fail_count++;
            end
         end
      end
   end

   // Ends the run if neither a word nor a result moves for too long.
   initial begin : stall_watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_results.size());
      $display("masked_word_pattern_scanner verification failed");
      $finish;
   end

   initial begin
      reset             <= 1'b1;
      csr_write_en      <= 1'b0;
      csr_index         <= mwps_pkg::CSR_PATTERN_FIRST;
      csr_wdata         <= '0;
      req_if.valid      <= 1'b0;
      req_if.image_word <= '0;
      req_if.final_word <= 1'b0;
      reset_scan_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_windows();
      test_random_images();
      test_result_backpressure();
      test_steady_stream();

      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("masked_word_pattern_scanner verification clean");
      else
         $display("masked_word_pattern_scanner verification failed");
      $finish;
   end

endmodule
